>>> rtl/core/rsb_pkg.sv
// Shared types and constants of the rank sum bias Z score unit.
`timescale 1ns / 1ps
package rsb_pkg;

    localparam int unsigned SCORE_CAP = 254;
    localparam int unsigned U_BITS    = 42;
    localparam int unsigned N_BITS    = 20;
    localparam int unsigned FRAC_BITS = 32;
    localparam int unsigned ROOT_BITS = 32;
    localparam int unsigned Z_BITS    = 32;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [1:0] MODE_BQ   = 2'd0;
    localparam logic [1:0] MODE_MQ   = 2'd1;
    localparam logic [1:0] MODE_DIST = 2'd2;

    typedef enum logic [1:0] {
        REG_SCORE_MODE = 2'd0,
        REG_MAJOR      = 2'd1,
        REG_MINOR      = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  base_code;
        logic [7:0]  base_quality;
        logic [7:0]  mapping_quality;
        logic [15:0] start_distance;
        logic [15:0] end_distance;
    } t_req;

    typedef struct packed {
        logic signed [31:0] z_score;
        logic [41:0]        twice_u_major_side;
        logic [41:0]        twice_u_minor_side;
        logic [19:0]        major_count;
        logic [19:0]        minor_count;
        logic               undefined_flag;
    } t_resp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_BIN_RD,
        S_MUL_GO,
        S_MUL_WT,
        S_BIN_NEXT,
        S_CHECK,
        S_DIV_INIT,
        S_DIV,
        S_SQ_INIT,
        S_SQ,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MEM_IDLE,
        MEM_CLEAR,
        MEM_ADD_RD,
        MEM_ADD_WR,
        MEM_WALK
    } t_mem_op;

    typedef enum logic [2:0] {
        MS_P,
        MS_Q,
        MS_T,
        MS_DSQ,
        MS_V1,
        MS_V2
    } t_msel;

    typedef struct packed {
        t_mem_op mem_op;
        logic    cap_add;
        logic    fin_init;
        logic    mul_start;
        logic    acc_en;
        t_msel   msel;
        logic    bin_next;
        logic    div_init;
        logic    div_step;
        logic    sq_init;
        logic    sq_step;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic undef;
    } t_stat;

endpackage

>>> rtl/core/rsb_mul.sv
// Shift-add multiplier, one multiplier bit per cycle with early exit.
`timescale 1ns / 1ps
module rsb_mul #(
    parameter int unsigned A_WIDTH = 112,
    parameter int unsigned B_WIDTH = 56
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_WIDTH-1:0] i_a,
    input  logic [B_WIDTH-1:0] i_b,
    output logic               o_done,
    output logic [A_WIDTH-1:0] o_prod
);

    logic               r_busy;
    logic [A_WIDTH-1:0] r_a;
    logic [B_WIDTH-1:0] r_b;
    logic [A_WIDTH-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_b == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_busy && (r_b == '0);
    assign o_prod = r_p;

endmodule

>>> rtl/core/rsb_dp.sv
// Datapath: histograms, rank sum accumulators, divider, square root, result register.
`timescale 1ns / 1ps
module rsb_dp #(
    parameter int unsigned NUM_BINS   = 255,
    parameter int unsigned COUNT_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rsb_pkg::t_cmd                 i_cmd,
    input  logic [$clog2(NUM_BINS)-1:0]   i_idx,
    input  rsb_pkg::t_req                 i_req,
    input  logic [1:0]                    i_score_mode,
    input  logic [1:0]                    i_major,
    input  logic [1:0]                    i_minor,
    output rsb_pkg::t_stat                o_stat,
    output rsb_pkg::t_resp                o_resp
);
    import rsb_pkg::*;

    localparam int AW  = $clog2(NUM_BINS);
    localparam int NW  = COUNT_BITS + $clog2(NUM_BINS);
    localparam int PW  = 2 * NW;
    localparam int MW  = 4 * NW;
    localparam int VW  = 3 * NW + 1;
    localparam int RW  = MW + 2 + FRAC_BITS;
    localparam int XW  = (PW + 1 > U_BITS + 1) ? PW + 1 : U_BITS + 1;
    localparam int CXW = (NW > N_BITS + 1) ? NW : N_BITS + 1;
    localparam int SCORE_LIM = (NUM_BINS - 1 < SCORE_CAP) ? NUM_BINS - 1 : SCORE_CAP;
    localparam logic [XW-1:0]  U_MAX   = XW'((64'd1 << U_BITS) - 64'd1);
    localparam logic [CXW-1:0] CNT_MAX = CXW'((64'd1 << N_BITS) - 64'd1);

    logic [COUNT_BITS-1:0] r_maj_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] r_min_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] r_rd_maj, r_rd_min;

    logic [AW-1:0] r_add_addr;
    logic          r_add_maj, r_add_hit;

    logic [PW-1:0] r_p, r_q, r_t, r_v1;
    logic [NW-1:0] r_n1, r_n2;
    logic [MW-1:0] r_dsq;
    logic [VW-1:0] r_v;

    logic [RW-1:0] r_dq;
    logic [VW-1:0] r_rem;

    logic [63:0]          r_sx;
    logic [ROOT_BITS:0]   r_srem;
    logic [ROOT_BITS-1:0] r_root;

    t_resp r_resp;

    logic [15:0]   w_dist, w_score;
    logic [AW-1:0] w_addr, w_mem_addr;
    logic          w_is_maj, w_is_min;
    logic [PW-1:0] w_d;
    logic [NW:0]   w_nsum;
    logic [MW-1:0] w_mul_a, w_prod;
    logic [PW-1:0] w_mul_b;
    logic          w_mul_done;
    logic [VW:0]   w_trial;
    logic          w_qbit;
    logic [MW+1:0] w_r3;
    logic          w_qsat;
    logic [ROOT_BITS+2:0] w_srem_sh, w_strial;
    logic [XW-1:0] w_x_maj, w_x_min;

    // Pick and clamp the score of one observation.
    always_comb begin
        w_dist = (i_req.start_distance < i_req.end_distance) ?
                 i_req.start_distance : i_req.end_distance;
        case (i_score_mode)
            MODE_MQ:   w_score = {8'd0, i_req.mapping_quality};
            MODE_DIST: w_score = w_dist;
            default:   w_score = {8'd0, i_req.base_quality};
        endcase
        w_addr   = (w_score > 16'(SCORE_LIM)) ? AW'(SCORE_LIM) : w_score[AW-1:0];
        w_is_maj = (i_req.base_code == {1'b0, i_major});
        w_is_min = (i_req.base_code == {1'b0, i_minor});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_add) begin
            r_add_addr <= w_addr;
            r_add_maj  <= w_is_maj;
            r_add_hit  <= w_is_maj | w_is_min;
        end
    end

    assign w_mem_addr = ((i_cmd.mem_op == MEM_ADD_RD) || (i_cmd.mem_op == MEM_ADD_WR)) ?
                        r_add_addr : i_idx;

    always_ff @(posedge i_clk) begin
        case (i_cmd.mem_op)
            MEM_CLEAR: begin
                r_maj_mem[w_mem_addr] <= '0;
                r_min_mem[w_mem_addr] <= '0;
            end
            MEM_ADD_RD: begin
                r_rd_maj <= r_maj_mem[w_mem_addr];
                r_rd_min <= r_min_mem[w_mem_addr];
            end
            MEM_ADD_WR: begin
                if (r_add_hit && r_add_maj && (r_rd_maj != '1)) begin
                    r_maj_mem[w_mem_addr] <= r_rd_maj + 1'b1;
                end
                if (r_add_hit && !r_add_maj && (r_rd_min != '1)) begin
                    r_min_mem[w_mem_addr] <= r_rd_min + 1'b1;
                end
            end
            MEM_WALK: begin
                // read the bin and empty it for the next site
                r_rd_maj <= r_maj_mem[w_mem_addr];
                r_rd_min <= r_min_mem[w_mem_addr];
                r_maj_mem[w_mem_addr] <= '0;
                r_min_mem[w_mem_addr] <= '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_d    = (r_p >= r_q) ? (r_p - r_q) : (r_q - r_p);
        w_nsum = (NW+1)'(r_n1) + (NW+1)'(r_n2) + (NW+1)'(1);
        case (i_cmd.msel)
            MS_P:    begin w_mul_a = MW'(r_n1);     w_mul_b = PW'(r_rd_min); end
            MS_Q:    begin w_mul_a = MW'(r_n2);     w_mul_b = PW'(r_rd_maj); end
            MS_T:    begin w_mul_a = MW'(r_rd_maj); w_mul_b = PW'(r_rd_min); end
            MS_DSQ:  begin w_mul_a = MW'(w_d);      w_mul_b = w_d;           end
            MS_V1:   begin w_mul_a = MW'(r_n1);     w_mul_b = PW'(r_n2);     end
            MS_V2:   begin w_mul_a = MW'(r_v1);     w_mul_b = PW'(w_nsum);   end
            default: begin w_mul_a = '0;            w_mul_b = '0;            end
        endcase
    end

    rsb_mul #(
        .A_WIDTH(MW),
        .B_WIDTH(PW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.mul_start),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_done (w_mul_done),
        .o_prod (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_init) begin
            r_p  <= '0;
            r_q  <= '0;
            r_t  <= '0;
            r_n1 <= '0;
            r_n2 <= '0;
        end else begin
            if (i_cmd.acc_en) begin
                case (i_cmd.msel)
                    MS_P:    r_p   <= r_p + PW'(w_prod);
                    MS_Q:    r_q   <= r_q + PW'(w_prod);
                    MS_T:    r_t   <= r_t + PW'(w_prod);
                    MS_DSQ:  r_dsq <= w_prod;
                    MS_V1:   r_v1  <= PW'(w_prod);
                    MS_V2:   r_v   <= VW'(w_prod);
                    default: ;
                endcase
            end
            if (i_cmd.bin_next) begin
                r_n1 <= r_n1 + NW'(r_rd_maj);
                r_n2 <= r_n2 + NW'(r_rd_min);
            end
        end
    end

    // Restoring division of 3*D^2*2^32 by V, one quotient bit a cycle.
    always_comb begin
        w_r3    = (MW+2)'({r_dsq, 1'b0}) + (MW+2)'(r_dsq);
        w_trial = {r_rem, r_dq[RW-1]};
        w_qbit  = (w_trial >= {1'b0, r_v});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_dq  <= {w_r3, {FRAC_BITS{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? VW'(w_trial - {1'b0, r_v}) : w_trial[VW-1:0];
            r_dq  <= {r_dq[RW-2:0], w_qbit};
        end
    end

    assign w_qsat = |r_dq[RW-1:2*ROOT_BITS-2];

    // Integer square root, one root bit a cycle.
    always_comb begin
        w_srem_sh = {r_srem, r_sx[63:62]};
        w_strial  = {1'b0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_init) begin
            r_sx   <= {2'b00, r_dq[2*ROOT_BITS-3:0]};
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_sx <= r_sx << 2;
            if (w_srem_sh >= w_strial) begin
                r_srem <= (ROOT_BITS+1)'(w_srem_sh - w_strial);
                r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                r_srem <= w_srem_sh[ROOT_BITS:0];
                r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        w_x_maj = XW'({r_p, 1'b0}) + XW'(r_t);
        w_x_min = XW'({r_q, 1'b0}) + XW'(r_t);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_resp.twice_u_major_side <= (w_x_maj > U_MAX) ? '1 : w_x_maj[U_BITS-1:0];
            r_resp.twice_u_minor_side <= (w_x_min > U_MAX) ? '1 : w_x_min[U_BITS-1:0];
            r_resp.major_count <= (CXW'(r_n1) > CNT_MAX) ? '1 : N_BITS'(r_n1);
            r_resp.minor_count <= (CXW'(r_n2) > CNT_MAX) ? '1 : N_BITS'(r_n2);
            r_resp.undefined_flag <= o_stat.undef;
            if (o_stat.undef) begin
                r_resp.z_score <= '0;
            end else if (w_qsat) begin
                r_resp.z_score <= {1'b1, {(Z_BITS-1){1'b0}}};
            end else begin
                r_resp.z_score <= $signed(Z_BITS'(0) - Z_BITS'(r_root));
            end
        end
    end

    assign o_stat.mul_done = w_mul_done;
    assign o_stat.undef    = (r_n1 == '0) || (r_n2 == '0);
    assign o_resp          = r_resp;

endmodule

>>> rtl/core/rsb_ctrl.sv
// Controller state machine: clearing pass, add, bin walk, divide and root sequencing.
`timescale 1ns / 1ps
module rsb_ctrl #(
    parameter int unsigned NUM_BINS   = 255,
    parameter int unsigned COUNT_BITS = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_cmd,
    output logic                        o_req_ready,
    output logic                        o_resp_valid,
    input  logic                        i_resp_ready,
    input  rsb_pkg::t_stat              i_stat,
    output rsb_pkg::t_cmd               o_cmd,
    output logic [$clog2(NUM_BINS)-1:0] o_idx
);
    import rsb_pkg::*;

    localparam int AW   = $clog2(NUM_BINS);
    localparam int NW   = COUNT_BITS + $clog2(NUM_BINS);
    localparam int RW   = 4 * NW + 2 + FRAC_BITS;
    localparam int CMAX = (NUM_BINS > RW) ? NUM_BINS : RW;
    localparam int CNTW = $clog2(CMAX + 1);
    localparam logic [CNTW-1:0] BIN_LAST  = CNTW'(NUM_BINS - 1);
    localparam logic [CNTW-1:0] DIV_LAST  = CNTW'(RW - 1);
    localparam logic [CNTW-1:0] ROOT_LAST = CNTW'(ROOT_BITS - 1);

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    t_msel           r_msel, n_msel;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_msel      <= MS_P;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_msel      <= n_msel;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_msel      = r_msel;
        n_out_valid = r_out_valid && !i_resp_ready;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == BIN_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_cnt   = '0;
                    n_state = (i_req_cmd == CMD_FINISH) ? S_BIN_RD : S_ADD_RD;
                end
            end
            S_ADD_RD: n_state = S_ADD_WR;
            S_ADD_WR: n_state = S_IDLE;
            S_BIN_RD: begin
                n_msel  = MS_P;
                n_state = S_MUL_GO;
            end
            S_MUL_GO: n_state = S_MUL_WT;
            S_MUL_WT: begin
                if (i_stat.mul_done) begin
                    case (r_msel)
                        MS_P:    begin n_msel = MS_Q;  n_state = S_MUL_GO;   end
                        MS_Q:    begin n_msel = MS_T;  n_state = S_MUL_GO;   end
                        MS_T:    n_state = S_BIN_NEXT;
                        MS_DSQ:  begin n_msel = MS_V1; n_state = S_MUL_GO;   end
                        MS_V1:   begin n_msel = MS_V2; n_state = S_MUL_GO;   end
                        MS_V2:   n_state = S_DIV_INIT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_BIN_NEXT: begin
                if (r_cnt == BIN_LAST) begin
                    n_cnt   = '0;
                    n_state = S_CHECK;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_BIN_RD;
                end
            end
            S_CHECK: begin
                if (i_stat.undef) begin
                    n_state = S_OUT;
                end else begin
                    n_msel  = MS_DSQ;
                    n_state = S_MUL_GO;
                end
            end
            S_DIV_INIT: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_SQ_INIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQ_INIT: begin
                n_cnt   = '0;
                n_state = S_SQ;
            end
            S_SQ: begin
                if (r_cnt == ROOT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_resp_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.mem_op = MEM_IDLE;
        o_cmd.msel   = r_msel;
        o_req_ready  = 1'b0;
        case (r_state)
            S_CLEAR:    o_cmd.mem_op = MEM_CLEAR;
            S_IDLE: begin
                o_req_ready    = 1'b1;
                o_cmd.cap_add  = i_req_valid && (i_req_cmd == CMD_ADD);
                o_cmd.fin_init = i_req_valid && (i_req_cmd == CMD_FINISH);
            end
            S_ADD_RD:   o_cmd.mem_op    = MEM_ADD_RD;
            S_ADD_WR:   o_cmd.mem_op    = MEM_ADD_WR;
            S_BIN_RD:   o_cmd.mem_op    = MEM_WALK;
            S_MUL_GO:   o_cmd.mul_start = 1'b1;
            S_MUL_WT:   o_cmd.acc_en    = i_stat.mul_done;
            S_BIN_NEXT: o_cmd.bin_next  = 1'b1;
            S_DIV_INIT: o_cmd.div_init  = 1'b1;
            S_DIV:      o_cmd.div_step  = 1'b1;
            S_SQ_INIT:  o_cmd.sq_init   = 1'b1;
            S_SQ:       o_cmd.sq_step   = 1'b1;
            S_OUT:      o_cmd.out_load  = !r_out_valid || i_resp_ready;
            default:    ;
        endcase
    end

    assign o_idx        = r_cnt[AW-1:0];
    assign o_resp_valid = r_out_valid;

endmodule

>>> rtl/core/rank_sum_bias_z_score_unit.sv
// Top level of the rank sum bias Z score unit: configuration registers and wiring.
//
//  channel   direction  handshake                     payload
//  request   in         i_req_valid / o_req_ready     i_req  (rsb_pkg::t_req)
//  response  out        o_resp_valid / i_resp_ready   o_resp (rsb_pkg::t_resp)
//  config    in         psel, penable, pwrite, pready paddr, pwdata / prdata
//
// An add request goes through accept, histogram read and histogram write in turn.
// A finish request walks all NUM_BINS bins; each bin takes three multiplies
// in the shared shift-add multiplier, whose run grows with the bit length of
// the multiplier operand; then three more multiplies, a restoring divide of
// 4*NW+34 steps and a 32-step square root follow (NW = COUNT_BITS +
// clog2(NUM_BINS)). The walk empties the histograms as it reads them.
// After reset a clearing pass over all NUM_BINS bins runs before the first
// request is taken; configuration writes are taken throughout.
// A finished response waits in the output register; add requests keep
// flowing meanwhile, and a later finish holds only at its final load.
`timescale 1ns / 1ps
module rank_sum_bias_z_score_unit #(
    parameter int unsigned NUM_BINS   = 255,
    parameter int unsigned COUNT_BITS = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  rsb_pkg::t_req  i_req,
    output logic           o_resp_valid,
    input  logic           i_resp_ready,
    output rsb_pkg::t_resp o_resp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import rsb_pkg::*;

    logic [1:0] r_score_mode, r_major, r_minor;
    logic       w_wr;

    t_cmd                    w_cmd;
    t_stat                   w_stat;
    logic [$clog2(NUM_BINS)-1:0] w_idx;

    // Write on the access phase; the port never stalls.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_mode <= MODE_BQ;
            r_major      <= 2'd0;
            r_minor      <= 2'd1;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_SCORE_MODE: r_score_mode <= pwdata[1:0];
                REG_MAJOR:      r_major      <= pwdata[1:0];
                REG_MINOR:      r_minor      <= pwdata[1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SCORE_MODE: prdata = {30'd0, r_score_mode};
            REG_MAJOR:      prdata = {30'd0, r_major};
            REG_MINOR:      prdata = {30'd0, r_minor};
            default:        prdata = '0;
        endcase
    end

    // Sequence every request through the controller.
    rsb_ctrl #(
        .NUM_BINS  (NUM_BINS),
        .COUNT_BITS(COUNT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_cmd   (i_req.cmd),
        .o_req_ready (o_req_ready),
        .o_resp_valid(o_resp_valid),
        .i_resp_ready(i_resp_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_idx       (w_idx)
    );

    // Hold histograms, sums and the response payload.
    rsb_dp #(
        .NUM_BINS  (NUM_BINS),
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_idx       (w_idx),
        .i_req       (i_req),
        .i_score_mode(r_score_mode),
        .i_major     (r_major),
        .i_minor     (r_minor),
        .o_stat      (w_stat),
        .o_resp      (o_resp)
    );

endmodule

>>> rtl/core/rsb_checker.sv
// Port-level checker for the rank sum bias Z score unit, bound to the top level.
`timescale 1ns / 1ps
module rsb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_resp_valid,
    input logic           i_resp_ready,
    input rsb_pkg::t_resp o_resp
);
    import rsb_pkg::*;

    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid && !i_resp_ready |=> o_resp_valid)
        else $error("response dropped while stalled");

    a_resp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid && !i_resp_ready |=> $stable(o_resp))
        else $error("response payload changed while stalled");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid && (o_resp.major_count == '0 || o_resp.minor_count == '0)
        |-> o_resp.undefined_flag && (o_resp.z_score == '0))
        else $error("empty allele without undefined flag and zero score");

    a_z_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid |-> (o_resp.z_score[31] || (o_resp.z_score == '0)))
        else $error("positive z score");

endmodule

bind rank_sum_bias_z_score_unit rsb_checker u_rsb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_resp_valid(o_resp_valid),
    .i_resp_ready(i_resp_ready),
    .o_resp      (o_resp)
);

>>> dv/testbench.sv
// Self-checking testbench for the rank sum bias Z score unit.
`timescale 1ns / 1ps
module testbench;
    import rsb_pkg::*;

    localparam int          BINS       = 255;
    localparam int          SETTLE     = 400;      // cycles for a trailing add to land
    localparam int          STALL_LIM  = 400000;   // longest finish walk, many times over
    localparam logic [63:0] CNT_SAT    = (64'd1 << 20) - 1;
    localparam logic [63:0] U_SAT      = (64'd1 << 42) - 1;
    localparam logic [63:0] BIN_SAT    = (64'd1 << 20) - 1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_req_valid;
    logic        o_req_ready;
    t_req        i_req;
    logic        o_resp_valid;
    logic        i_resp_ready;
    t_resp       o_resp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rank_sum_bias_z_score_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .o_resp       (o_resp),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Shadow of the block: histograms and configuration
    logic [63:0] major_tally [BINS];
    logic [63:0] minor_tally [BINS];
    logic [1:0]  mode_sh;
    logic [1:0]  major_sh;
    logic [1:0]  minor_sh;

    t_req  pending_reqs [$];
    t_resp site_results [$];
    int    idle_pct;
    int    stall_pct;
    int    errors;
    int    quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    // Tally one observation in the shadow histograms.
    function automatic void tally_obs(t_req r);
        logic [15:0] score;
        if (mode_sh == MODE_MQ) begin
            score = {8'd0, r.mapping_quality};
        end else if (mode_sh == MODE_DIST) begin
            score = (r.start_distance < r.end_distance) ? r.start_distance : r.end_distance;
        end else begin
            score = {8'd0, r.base_quality};
        end
        if (score > 16'(SCORE_CAP)) score = 16'(SCORE_CAP);
        if (r.base_code == {1'b0, major_sh}) begin
            if (major_tally[score] < BIN_SAT) major_tally[score]++;
        end else if (r.base_code == {1'b0, minor_sh}) begin
            if (minor_tally[score] < BIN_SAT) minor_tally[score]++;
        end
    endfunction

    // Walk and empty the shadow bins, then form 2*U1, 2*U2 and the Q16.16 Z.
    function automatic t_resp score_site();
        t_resp       res;
        logic [191:0] p, q, t, a, c, n1, n2, x, y, d, v, r, cand, m;
        p = '0; q = '0; t = '0; n1 = '0; n2 = '0; m = '0;
        for (int i = 0; i < BINS; i++) begin
            a = 192'(major_tally[i]);
            c = 192'(minor_tally[i]);
            p += c * n1;
            q += a * n2;
            t += a * c;
            n1 += a;
            n2 += c;
            major_tally[i] = '0;
            minor_tally[i] = '0;
        end
        x = 2 * p + t;
        y = 2 * q + t;
        res.twice_u_major_side = (x > U_SAT) ? U_SAT[41:0] : x[41:0];
        res.twice_u_minor_side = (y > U_SAT) ? U_SAT[41:0] : y[41:0];
        res.major_count = (n1 > CNT_SAT) ? CNT_SAT[19:0] : n1[19:0];
        res.minor_count = (n2 > CNT_SAT) ? CNT_SAT[19:0] : n2[19:0];
        if (n1 == 0 || n2 == 0) begin
            res.z_score = '0;
            res.undefined_flag = 1'b1;
        end else begin
            d = (p >= q) ? p - q : q - p;
            v = n1 * n2 * (n1 + n2 + 1);
            r = (d * d * 3) << 32;
            // largest magnitude whose square times v stays within r
            for (int b = 31; b >= 0; b--) begin
                cand = m | (192'd1 << b);
                if (cand * cand * v <= r) m = cand;
            end
            if (m > (192'd1 << 31)) m = 192'd1 << 31;
            res.z_score = 32'd0 - m[31:0];
            res.undefined_flag = 1'b0;
        end
        return res;
    endfunction

    // Driver: hold the request until accepted, predict on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else begin
            if (i_req_valid && o_req_ready) begin
                if (i_req.cmd == CMD_FINISH) site_results.push_back(score_site());
                else tally_obs(i_req);
            end
            if (!i_req_valid || o_req_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    i_req       <= pending_reqs.pop_front();
                    i_req_valid <= 1'b1;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, check each response against the oldest prediction.
    always @(posedge i_clk) begin
        t_resp want;
        if (!i_rst_n) begin
            i_resp_ready <= 1'b0;
        end else begin
            if (o_resp_valid && i_resp_ready) begin
                if (site_results.size() == 0) begin
                    $display("%0t: unexpected response z=%h", $time, o_resp.z_score);
                    errors++;
                end else begin
                    want = site_results.pop_front();
                    if (o_resp !== want) begin
                        $display("%0t: mismatch exp z=%h u1=%h u2=%h n1=%h n2=%h und=%b",
                                 $time, want.z_score, want.twice_u_major_side,
                                 want.twice_u_minor_side, want.major_count,
                                 want.minor_count, want.undefined_flag);
                        $display("%0t:          act z=%h u1=%h u2=%h n1=%h n2=%h und=%b",
                                 $time, o_resp.z_score, o_resp.twice_u_major_side,
                                 o_resp.twice_u_minor_side, o_resp.major_count,
                                 o_resp.minor_count, o_resp.undefined_flag);
                        errors++;
                    end
                end
            end
            i_resp_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: count cycles with no request or response moving.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_resp_valid && i_resp_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIM) begin
                $display("rank_sum_bias_z_score_unit test failed");
                $finish;
            end
        end
    end

    // Write one register through the setup and access cycles.
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SCORE_MODE: mode_sh  = val[1:0];
            REG_MAJOR:      major_sh = val[1:0];
            default:        minor_sh = val[1:0];
        endcase
    endtask

    // Hold until every request is taken and every response is back, then let adds settle.
    task automatic drain();
        while (pending_reqs.size() > 0 || i_req_valid || site_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_req mk_req(logic cmd, logic [2:0] base, logic [7:0] bq,
                                    logic [7:0] mq, logic [15:0] sd, logic [15:0] ed);
        t_req r;
        r.cmd             = cmd;
        r.base_code       = base;
        r.base_quality    = bq;
        r.mapping_quality = mq;
        r.start_distance  = sd;
        r.end_distance    = ed;
        return r;
    endfunction

    // Queue one site: a run of observations with random content, then a finish.
    task automatic queue_site(int n_obs);
        int qmax;
        int dmax;
        int pick;
        logic [2:0] base;
        qmax = ($urandom_range(0, 2) == 0) ? 3 : (($urandom_range(0, 1) == 0) ? 30 : 255);
        dmax = ($urandom_range(0, 2) == 0) ? 5 : (($urandom_range(0, 1) == 0) ? 300 : 65535);
        for (int i = 0; i < n_obs; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)      base = {1'b0, major_sh};
            else if (pick < 8) base = {1'b0, minor_sh};
            else               base = 3'($urandom_range(0, 7));
            pending_reqs.push_back(mk_req(CMD_ADD, base, 8'($urandom_range(0, qmax)),
                                          8'($urandom_range(0, qmax)),
                                          16'($urandom_range(0, dmax)),
                                          16'($urandom_range(0, dmax))));
        end
        pending_reqs.push_back(mk_req(CMD_FINISH, 3'($urandom), 8'($urandom), 8'($urandom),
                                      16'($urandom), 16'($urandom)));
    endtask

    initial begin
        logic [1:0] cfg [6][3];
        int phase_items;
        cfg = '{'{2'd0, 2'd0, 2'd1}, '{2'd1, 2'd2, 2'd3}, '{2'd2, 2'd3, 2'd0},
                '{2'd3, 2'd1, 2'd1}, '{2'd2, 2'd0, 2'd3}, '{2'd1, 2'd3, 2'd2}};
        i_rst_n      = 1'b0;
        i_req_valid  = 1'b0;
        i_req        = '0;
        i_resp_ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        errors       = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        mode_sh      = MODE_BQ;
        major_sh     = 2'd0;
        minor_sh     = 2'd1;
        for (int i = 0; i < BINS; i++) begin
            major_tally[i] = '0;
            minor_tally[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: finish on empty bins, extremes, unknown bases, one-sided sites.
        pending_reqs.push_back(mk_req(CMD_FINISH, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd0, 8'd255, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd0, 8'd0, 8'd255, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(mk_req(CMD_FINISH, 3'd7, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd1, 8'd254, 8'd1, 16'd1, 16'd2));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd4, 8'd10, 8'd10, 16'd10, 16'd10));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd7, 8'd10, 8'd10, 16'd10, 16'd10));
        pending_reqs.push_back(mk_req(CMD_FINISH, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd0, 8'd255, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd1, 8'd254, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd1, 8'd7, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd1, 8'd0, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_FINISH, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd0, 8'd200, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd0, 8'd201, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd1, 8'd0, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_ADD, 3'd1, 8'd1, 8'd0, 16'd0, 16'd0));
        pending_reqs.push_back(mk_req(CMD_FINISH, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0));
        // Sender pauses here until every response is back.
        drain();

        // Random phases: each with its own register setting and one of four idling patterns.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_SCORE_MODE, {30'($urandom), cfg[ph][0]});
            write_reg(REG_MAJOR, {30'd0, cfg[ph][1]});
            write_reg(REG_MINOR, {30'd0, cfg[ph][2]});
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            phase_items = 0;
            while (phase_items < 195) begin
                int n_obs;
                n_obs = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(0, 25);
                queue_site(n_obs);
                phase_items += n_obs + 1;
                // Hold off queueing more sites while over 40 requests are waiting.
                while (pending_reqs.size() > 40) @(posedge i_clk);
            end
            drain();
        end

        if (errors == 0) begin
            $display("rank_sum_bias_z_score_unit test passed");
        end else begin
            $display("rank_sum_bias_z_score_unit test failed");
        end
        $finish;
    end

endmodule
